// ===== rtl/esc_pkg.sv =====
// Shared types, constants and microcode table for the epoch-to-calendar converter.
package esc_pkg;

  localparam int unsigned EpochW = 32;
  localparam int unsigned PcW    = 4;
  localparam int unsigned RemW   = 6;

  typedef logic [PcW-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_DIV_MUL,
    OP_DIV_FIX,
    OP_YEAR,
    OP_MONTH,
    OP_DONE
  } op_e;

  typedef enum logic [1:0] {
    DIV_60,
    DIV_24,
    DIV_7
  } divsel_e;

  typedef enum logic [1:0] {
    DST_SEC,
    DST_MIN,
    DST_HR,
    DST_WDAY
  } dest_e;

  typedef struct packed {
    op_e     op;
    divsel_e div;
    dest_e   dest;
    logic    load_t;
    pc_t     jmp;
  } uword_t;

  typedef struct packed {
    logic    mul_en;
    divsel_e sel;
  } div_ctrl_t;

  localparam pc_t PcYear  = 4'd8;
  localparam pc_t PcMonth = 4'd9;

  localparam logic [EpochW-1:0] Recip60 = 32'(64'h1_0000_0000 / 64'd60);
  localparam logic [EpochW-1:0] Recip24 = 32'(64'h1_0000_0000 / 64'd24);
  localparam logic [EpochW-1:0] Recip7  = 32'(64'h1_0000_0000 / 64'd7);

  localparam logic [7:0] Yoff2100 = 8'(2100 - 1970);
  localparam logic [7:0] Yoff2200 = 8'(2200 - 1970);
  localparam logic [7:0] YoffMax  = 8'd136;
  localparam logic [3:0] MonFeb   = 4'd1;
  localparam logic [3:0] MonLast  = 4'd11;

  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    w = '{op: OP_DONE, div: DIV_60, dest: DST_SEC, load_t: 1'b0, jmp: '0};
    unique case (pc)
      4'd0: w = '{op: OP_DIV_MUL, div: DIV_60, dest: DST_SEC,  load_t: 1'b0, jmp: '0};
      4'd1: w = '{op: OP_DIV_FIX, div: DIV_60, dest: DST_SEC,  load_t: 1'b1, jmp: '0};
      4'd2: w = '{op: OP_DIV_MUL, div: DIV_60, dest: DST_MIN,  load_t: 1'b0, jmp: '0};
      4'd3: w = '{op: OP_DIV_FIX, div: DIV_60, dest: DST_MIN,  load_t: 1'b1, jmp: '0};
      4'd4: w = '{op: OP_DIV_MUL, div: DIV_24, dest: DST_HR,   load_t: 1'b0, jmp: '0};
      4'd5: w = '{op: OP_DIV_FIX, div: DIV_24, dest: DST_HR,   load_t: 1'b1, jmp: '0};
      4'd6: w = '{op: OP_DIV_MUL, div: DIV_7,  dest: DST_WDAY, load_t: 1'b0, jmp: '0};
      4'd7: w = '{op: OP_DIV_FIX, div: DIV_7,  dest: DST_WDAY, load_t: 1'b0, jmp: '0};
      4'd8: w = '{op: OP_YEAR,    div: DIV_60, dest: DST_SEC,  load_t: 1'b0, jmp: PcYear};
      4'd9: w = '{op: OP_MONTH,   div: DIV_60, dest: DST_SEC,  load_t: 1'b0, jmp: PcMonth};
      default: w = '{op: OP_DONE, div: DIV_60, dest: DST_SEC, load_t: 1'b0, jmp: '0};
    endcase
    return w;
  endfunction

  function automatic logic [RemW-1:0] divisor(divsel_e sel);
    logic [RemW-1:0] d;
    unique case (sel)
      DIV_60:  d = 6'd60;
      DIV_24:  d = 6'd24;
      DIV_7:   d = 6'd7;
      default: d = 6'd60;
    endcase
    return d;
  endfunction

  function automatic logic [EpochW-1:0] recip(divsel_e sel);
    logic [EpochW-1:0] r;
    unique case (sel)
      DIV_60:  r = Recip60;
      DIV_24:  r = Recip24;
      DIV_7:   r = Recip7;
      default: r = Recip60;
    endcase
    return r;
  endfunction

  function automatic logic is_leap(logic [7:0] yoff);
    return (yoff[1:0] == 2'd2) && (yoff != Yoff2100) && (yoff != Yoff2200);
  endfunction

  function automatic logic [8:0] year_len(logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] mon, logic leap);
    logic [4:0] len;
    case (mon) inside
      MonFeb:                    len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // day 0 of the epoch was a Thursday
  function automatic logic [2:0] wday_of(logic [2:0] rem);
    return (rem >= 3'd3) ? 3'(rem - 3'd2) : 3'(rem + 3'd5);
  endfunction

endpackage

// ===== rtl/esc_divc.sv =====
// Divide-by-constant unit: reciprocal multiply, then one correction step.
module esc_divc (
  input  logic                              clk_i,
  input  esc_pkg::div_ctrl_t                ctrl_i,
  input  logic [esc_pkg::EpochW-1:0]        dividend_i,
  output logic [esc_pkg::EpochW-1:0]        quot_o,
  output logic [esc_pkg::RemW-1:0]          rem_o
);
  import esc_pkg::*;

  logic [2*EpochW-1:0] prod_q;
  logic [EpochW-1:0]   q_est;
  logic [EpochW-1:0]   r_full;
  logic [EpochW-1:0]   dvs;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= 64'(dividend_i) * 64'(recip(ctrl_i.sel));
    end
  end

  always_comb begin
    dvs    = 32'(divisor(ctrl_i.sel));
    q_est  = prod_q[2*EpochW-1:EpochW];
    r_full = dividend_i - 32'(q_est * dvs);
    if (r_full >= dvs) begin
      quot_o = q_est + 32'd1;
      rem_o  = RemW'(r_full - dvs);
    end else begin
      quot_o = q_est;
      rem_o  = RemW'(r_full);
    end
  end

endmodule

// ===== rtl/epoch_seconds_to_calendar.sv =====
// Top level: microcoded converter from epoch seconds to broken-down calendar time.
//
//   channel  direction  handshake              word
//   in       input      in_valid_i/in_ready_o  epoch_seconds_i
//   out      output     out_valid_o/out_ready_i seconds..day_of_month
//
// The year scan steps Y = years past 1970 (up to 136), one year per cycle; the month
// scan then steps M = month index (up to 11). The year scan sets the worst case.
// Four constant divisions (multiply step, fix step) share one reciprocal multiplier.
// Reset clears the sequencer and output valid; no clearing pass.
// A new word is taken while the last result waits; the final step holds until it drains.
module epoch_seconds_to_calendar (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [esc_pkg::EpochW-1:0]  epoch_seconds_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [5:0]                  seconds_o,
  output logic [5:0]                  minutes_o,
  output logic [4:0]                  hours_o,
  output logic [2:0]                  weekday_o,
  output logic [7:0]                  year_offset_o,
  output logic [3:0]                  month_o,
  output logic [4:0]                  day_of_month_o
);
  import esc_pkg::*;

  logic              busy_q, busy_d;
  pc_t               pc_q, pc_d;
  logic [EpochW-1:0] t_q, t_d;
  logic [5:0]        sec_q, sec_d;
  logic [5:0]        min_q, min_d;
  logic [4:0]        hr_q, hr_d;
  logic [2:0]        wday_q, wday_d;
  logic [7:0]        yoff_q, yoff_d;
  logic [3:0]        mon_q, mon_d;
  logic              out_valid_q, out_valid_d;

  uword_t            uw;
  div_ctrl_t         div_ctrl;
  logic [EpochW-1:0] div_quot;
  logic [RemW-1:0]   div_rem;
  logic              leap;
  logic [8:0]        ylen;
  logic [4:0]        mlen;
  logic              year_go;
  logic              month_go;
  logic              done_fire;
  logic              in_fire;

  assign uw        = ucode(pc_q);
  assign leap      = is_leap(yoff_q);
  assign ylen      = year_len(leap);
  assign mlen      = month_len(mon_q, leap);
  assign year_go   = t_q >= 32'(ylen);
  assign month_go  = (t_q >= 32'(mlen)) && (mon_q != MonLast);
  assign in_ready_o = !busy_q;
  assign in_fire   = in_valid_i && in_ready_o;
  assign done_fire = busy_q && (uw.op == OP_DONE) && (!out_valid_q || out_ready_i);

  assign div_ctrl.mul_en = busy_q && (uw.op == OP_DIV_MUL);
  assign div_ctrl.sel    = uw.div;

  esc_divc u_divc (
    .clk_i      (clk_i),
    .ctrl_i     (div_ctrl),
    .dividend_i (t_q),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    t_d    = t_q;
    sec_d  = sec_q;
    min_d  = min_q;
    hr_d   = hr_q;
    wday_d = wday_q;
    yoff_d = yoff_q;
    mon_d  = mon_q;
    if (in_fire) begin
      busy_d = 1'b1;
      pc_d   = '0;
      t_d    = epoch_seconds_i;
      yoff_d = '0;
      mon_d  = '0;
    end else if (busy_q) begin
      unique case (uw.op)
        OP_DIV_MUL: pc_d = pc_q + 4'd1;
        OP_DIV_FIX: begin
          pc_d = pc_q + 4'd1;
          if (uw.load_t) begin
            t_d = div_quot;
          end
          case (uw.dest)
            DST_SEC:  sec_d  = div_rem;
            DST_MIN:  min_d  = div_rem;
            DST_HR:   hr_d   = 5'(div_rem);
            DST_WDAY: wday_d = wday_of(3'(div_rem));
            default:  ;
          endcase
        end
        OP_YEAR: begin
          if (year_go) begin
            t_d    = t_q - 32'(ylen);
            yoff_d = yoff_q + 8'd1;
            pc_d   = uw.jmp;
          end else begin
            pc_d = pc_q + 4'd1;
          end
        end
        OP_MONTH: begin
          if (month_go) begin
            t_d   = t_q - 32'(mlen);
            mon_d = mon_q + 4'd1;
            pc_d  = uw.jmp;
          end else begin
            pc_d = pc_q + 4'd1;
          end
        end
        OP_DONE: begin
          if (done_fire) begin
            busy_d = 1'b0;
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (done_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    sec_q  <= sec_d;
    min_q  <= min_d;
    hr_q   <= hr_d;
    wday_q <= wday_d;
    yoff_q <= yoff_d;
    mon_q  <= mon_d;
    if (done_fire) begin
      seconds_o      <= sec_q;
      minutes_o      <= min_q;
      hours_o        <= hr_q;
      weekday_o      <= wday_q;
      year_offset_o  <= yoff_q;
      month_o        <= mon_q + 4'd1;
      day_of_month_o <= 5'(t_q) + 5'd1;
    end
  end

  assign out_valid_o = out_valid_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("sequencer not busy after accepting a word");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && uw.op == OP_DIV_FIX) |-> (div_rem < divisor(uw.div)))
    else $error("divider remainder not reduced");

  a_month_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && uw.op == OP_MONTH) |-> (mon_q <= MonLast && t_q < 32'd366))
    else $error("month scan out of range");

  a_year_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && uw.op == OP_YEAR) |-> (yoff_q <= YoffMax))
    else $error("year scan past last representable year");

endmodule
